// File: hdl/assert_macros.svh
// Assertion macros shared by the branch and jump unit modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define BJT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bjt assertion failed");

// Condition that must never be true outside reset.
`define BJT_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bjt forbidden condition seen");

`else

`define BJT_ASSERT(label, clk, rst_n, prop)
`define BJT_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: hdl/bjt_pkg.sv
// Types and constants of the branch and jump target unit.
`timescale 1ns / 1ps

package bjt_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [63:0] INSN_BYTES = 64'd4;

    typedef enum logic [3:0] {
        OP_JMP    = 4'd0,
        OP_GO     = 4'd1,
        OP_PUSHJ  = 4'd2,
        OP_PUSHGO = 4'd3,
        OP_POP    = 4'd4,
        OP_BN     = 4'd5,
        OP_BZ     = 4'd6,
        OP_BP     = 4'd7,
        OP_BOD    = 4'd8,
        OP_BNN    = 4'd9,
        OP_BNZ    = 4'd10,
        OP_BNP    = 4'd11,
        OP_BEV    = 4'd12
    } opcode_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_PUSH = 2'd1,
        ACT_POP  = 2'd2
    } stack_act_t;

    // One instruction beat on the input side
    typedef struct packed {
        logic [3:0]         opcode;
        logic               backward;
        logic [63:0]        pc;
        logic [7:0]         x_field;
        logic signed [63:0] x_value;
        logic [63:0]        y_value;
        logic [63:0]        z_value;
        logic               z_immediate;
        logic [7:0]         z_field;
        logic [23:0]        rel_offset;
    } item_t;

    // One resolved beat on the output side
    typedef struct packed {
        logic        taken;
        logic [63:0] next_pc;
        logic [63:0] link_value;
        logic        write_x;
        logic [1:0]  stack_action;
        logic [7:0]  stack_count;
    } result_t;

    // Classified instruction held in the queue between front and back
    typedef struct packed {
        logic        taken;
        logic        use_pop;     // next_pc = return register + target
        logic        load_ra;     // load return register with link
        logic [63:0] target;      // final target, or byte offset for pop
        logic [63:0] link;
        logic        write_x;
        logic [1:0]  stack_action;
        logic [7:0]  stack_count;
    } work_t;

endpackage

// File: hdl/bjt_front.sv
// Front end: decodes one instruction and computes its candidate targets.
`timescale 1ns / 1ps

module bjt_front (
    input  bjt_pkg::item_t item,
    output bjt_pkg::work_t work
);
    import bjt_pkg::*;

    logic [63:0] link;
    logic [63:0] delta;
    logic [63:0] rel_target;
    logic [63:0] z_addend;
    logic [63:0] ind_sum;
    logic [63:0] ind_target;
    logic        neg;
    logic        zero;
    logic        odd;
    logic        cond;

    // Address arithmetic, all modulo 2^64
    assign link       = item.pc + INSN_BYTES;
    assign delta      = {38'd0, item.rel_offset, 2'b00};
    assign rel_target = item.backward ? (item.pc - delta) : (item.pc + delta);
    assign z_addend   = item.z_immediate ? {56'd0, item.z_field} : item.z_value;
    assign ind_sum    = item.y_value + z_addend;
    assign ind_target = {ind_sum[63:3], 3'b000};

    // Flags of $X for the conditional branches
    assign neg  = item.x_value[63];
    assign zero = (item.x_value == 64'sd0);
    assign odd  = item.x_value[0];

    always_comb
    begin
        case (item.opcode)
            OP_BN:   cond = neg;
            OP_BZ:   cond = zero;
            OP_BP:   cond = !neg && !zero;
            OP_BOD:  cond = odd;
            OP_BNN:  cond = !neg;
            OP_BNZ:  cond = !zero;
            OP_BNP:  cond = neg || zero;
            OP_BEV:  cond = !odd;
            default: cond = 1'b0;
        endcase
    end

    // Classify the instruction
    always_comb
    begin
        work              = '0;
        work.link         = link;
        work.target       = link;
        work.stack_action = ACT_NONE;
        case (item.opcode)
            OP_JMP:
            begin
                work.taken  = 1'b1;
                work.target = rel_target;
            end
            OP_GO:
            begin
                work.taken   = 1'b1;
                work.target  = ind_target;
                work.write_x = 1'b1;
            end
            OP_PUSHJ:
            begin
                work.taken        = 1'b1;
                work.target       = rel_target;
                work.load_ra      = 1'b1;
                work.stack_action = ACT_PUSH;
                work.stack_count  = item.x_field;
            end
            OP_PUSHGO:
            begin
                work.taken        = 1'b1;
                work.target       = ind_target;
                work.load_ra      = 1'b1;
                work.stack_action = ACT_PUSH;
                work.stack_count  = item.x_field;
            end
            OP_POP:
            begin
                // pop always adds; the back end supplies the return register
                work.taken        = 1'b1;
                work.use_pop      = 1'b1;
                work.target       = delta;
                work.stack_action = ACT_POP;
                work.stack_count  = item.x_field;
            end
            default:
            begin
                if (item.opcode inside {[OP_BN:OP_BEV]} && cond)
                begin
                    work.taken  = 1'b1;
                    work.target = rel_target;
                end
            end
        endcase
    end

endmodule

// File: hdl/bjt_queue.sv
// Short queue of classified instructions between front and back end.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bjt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  bjt_pkg::work_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output bjt_pkg::work_t pop_data
);
    import bjt_pkg::*;

    work_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers, wrapping at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `BJT_ASSERT_NEVER(a_count_in_range, clk, rst_n, count_reg > QCNT_W'(QDEPTH))
    `BJT_ASSERT(a_fill_tracks_ptrs, clk, rst_n, (count_reg == '0 || count_reg == QCNT_W'(QDEPTH)) == (wr_ptr_reg == rd_ptr_reg))
    `BJT_ASSERT(a_push_only_grows, clk, rst_n, push && !pop |=> count_reg == $past(count_reg) + 1'b1)

endmodule

// File: hdl/bjt_back.sv
// Back end: applies the return register and holds the result beat.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bjt_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             work_valid,
    output logic             work_ready,
    input  bjt_pkg::work_t   work,
    output logic             result_valid,
    input  logic             result_ready,
    output bjt_pkg::result_t result
);
    import bjt_pkg::*;

    logic [63:0] ra_reg;
    logic [63:0] ra_next;
    logic        result_valid_reg;
    logic        result_valid_next;
    result_t     result_reg;
    result_t     result_next;
    logic        take;

    // Take a new beat whenever the output register is free or draining
    assign work_ready   = !result_valid_reg || result_ready;
    assign take         = work_valid && work_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        ra_next           = ra_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (take)
        begin
            result_valid_next        = 1'b1;
            result_next.taken        = work.taken;
            result_next.next_pc      = work.use_pop ? (ra_reg + work.target) : work.target;
            result_next.link_value   = work.link;
            result_next.write_x      = work.write_x;
            result_next.stack_action = work.stack_action;
            result_next.stack_count  = work.stack_count;
            if (work.load_ra)
            begin
                ra_next = work.link;
            end
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ra_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            ra_reg           <= ra_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    `BJT_ASSERT(a_ra_only_on_push, clk, rst_n, !$stable(ra_reg) |-> $past(take && work.load_ra))
    `BJT_ASSERT(a_result_from_take, clk, rst_n, $rose(result_valid_reg) |-> $past(take))
    `BJT_ASSERT_NEVER(a_bad_action, clk, rst_n, result_valid_reg && result_reg.stack_action == 2'd3)

endmodule

// File: hdl/branch_jump_target_unit.sv
// Branch and jump target unit: decode, queue and resolve jump-class instructions.
// A result beat is registered in the queue and then in the back end result register.
// Throughput: one item per cycle while result_ready holds; the front end adders are
// combinational, and a two-entry queue decouples them from the registered back end add.
// Reset: queue empties, no result is valid, return register clears to zero.
`timescale 1ns / 1ps

module branch_jump_target_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  bjt_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output bjt_pkg::result_t result
);
    import bjt_pkg::*;

    work_t front_work;
    work_t queue_work;
    logic  queue_valid;
    logic  queue_ready;

    bjt_front u_front (
        .item (item),
        .work (front_work)
    );

    bjt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (item_valid),
        .push_ready (item_ready),
        .push_data  (front_work),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_work)
    );

    bjt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .work_valid   (queue_valid),
        .work_ready   (queue_ready),
        .work         (queue_work),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the branch and jump target unit.
`timescale 1ns / 1ps

module testbench;
    import bjt_pkg::*;

    // Spare opcodes the unit treats as no operation
    localparam logic [3:0] OP_SPARE_FIRST = 4'd13;
    localparam logic [3:0] OP_SPARE_LAST  = 4'd15;

    localparam int RANDOM_INSNS = 1600;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 8;

    // Predict each resolved beat and hold the expectations in order.
    class jump_scoreboard;
        logic [63:0] return_reg;
        result_t     expected_q[$];
        int          mismatches;
        int          resolved;
        int          taken_seen;
        int          pushes;
        int          pops;
        int          spare_ops;

        function new();
            return_reg = '0;
            mismatches = 0;
            resolved   = 0;
            taken_seen = 0;
            pushes     = 0;
            pops       = 0;
            spare_ops  = 0;
        endfunction

        // Work out the result of one instruction and advance the return register.
        function result_t resolve(item_t insn);
            logic [63:0] link;
            logic [63:0] step;
            logic [63:0] rel_dest;
            logic [63:0] jump_dest;
            logic [63:0] z_addend;
            logic        neg;
            logic        zero;
            logic        odd;
            logic        rel_taken;
            result_t     r;
            link      = insn.pc + INSN_BYTES;
            step      = {38'd0, insn.rel_offset, 2'b00};
            rel_dest  = insn.backward ? insn.pc - step : insn.pc + step;
            z_addend  = insn.z_immediate ? {56'd0, insn.z_field} : insn.z_value;
            jump_dest = (insn.y_value + z_addend) & ~64'd7;
            neg       = insn.x_value[63];
            zero      = (insn.x_value == 64'd0);
            odd       = insn.x_value[0];
            rel_taken = 1'b0;
            r              = '0;
            r.next_pc      = link;
            r.link_value   = link;
            r.stack_action = ACT_NONE;
            case (insn.opcode)
                OP_JMP: rel_taken = 1'b1;
                OP_GO:
                begin
                    r.taken   = 1'b1;
                    r.next_pc = jump_dest;
                    r.write_x = 1'b1;
                end
                OP_PUSHJ:
                begin
                    rel_taken      = 1'b1;
                    r.stack_action = ACT_PUSH;
                    r.stack_count  = insn.x_field;
                    return_reg     = link;
                end
                OP_PUSHGO:
                begin
                    r.taken        = 1'b1;
                    r.next_pc      = jump_dest;
                    r.stack_action = ACT_PUSH;
                    r.stack_count  = insn.x_field;
                    return_reg     = link;
                end
                // Pop always adds, whatever the direction bit says
                OP_POP:
                begin
                    r.taken        = 1'b1;
                    r.next_pc      = return_reg + step;
                    r.stack_action = ACT_POP;
                    r.stack_count  = insn.x_field;
                end
                OP_BN:  rel_taken = neg;
                OP_BZ:  rel_taken = zero;
                OP_BP:  rel_taken = !neg && !zero;
                OP_BOD: rel_taken = odd;
                OP_BNN: rel_taken = !neg;
                OP_BNZ: rel_taken = !zero;
                OP_BNP: rel_taken = neg || zero;
                OP_BEV: rel_taken = !odd;
                default: ;
            endcase
            if (rel_taken)
            begin
                r.taken   = 1'b1;
                r.next_pc = rel_dest;
            end
            return r;
        endfunction

        function void note_insn(item_t insn);
            if (insn.opcode == OP_PUSHJ || insn.opcode == OP_PUSHGO)
                pushes++;
            if (insn.opcode == OP_POP)
                pops++;
            if (insn.opcode > OP_BEV)
                spare_ops++;
            expected_q.push_back(resolve(insn));
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // Compare one resolved beat with the oldest expectation.
        task check_resolved(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("result beat with nothing pending");
                return;
            end
            want = expected_q.pop_front();
            resolved++;
            if (want.taken)
                taken_seen++;
            if (got.taken !== want.taken)
                report_mismatch($sformatf("taken %0b, want %0b", got.taken, want.taken));
            if (got.next_pc !== want.next_pc)
                report_mismatch($sformatf("next_pc %h, want %h", got.next_pc, want.next_pc));
            if (got.link_value !== want.link_value)
                report_mismatch($sformatf("link_value %h, want %h",
                                          got.link_value, want.link_value));
            if (got.write_x !== want.write_x)
                report_mismatch($sformatf("write_x %0b, want %0b", got.write_x, want.write_x));
            if (got.stack_action !== want.stack_action)
                report_mismatch($sformatf("stack_action %0d, want %0d",
                                          got.stack_action, want.stack_action));
            if (got.stack_count !== want.stack_count)
                report_mismatch($sformatf("stack_count %0d, want %0d",
                                          got.stack_count, want.stack_count));
        endtask
    endclass

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    bit             steady;
    int             idle_cycles;
    int             hold_left;
    jump_scoreboard sb = new();

    branch_jump_target_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Mostly short idle gaps, now and then a long one; none in steady stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random instruction, weighted so that pushes and pops meet often
    function automatic item_t random_insn();
        item_t insn;
        int    pick;
        insn.backward    = 1'($urandom_range(0, 1));
        insn.pc          = rand64();
        insn.x_field     = 8'($urandom_range(0, 255));
        insn.y_value     = rand64();
        insn.z_value     = rand64();
        insn.z_immediate = 1'($urandom_range(0, 1));
        insn.z_field     = 8'($urandom_range(0, 255));
        insn.rel_offset  = $urandom_range(0, 9) == 0 ? 24'hFF_FFFF : 24'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 4)
            insn.opcode = 4'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        else if (pick < 12)
            insn.opcode = OP_PUSHJ;
        else if (pick < 18)
            insn.opcode = OP_PUSHGO;
        else if (pick < 32)
            insn.opcode = OP_POP;
        else if (pick < 42)
            insn.opcode = OP_JMP;
        else if (pick < 50)
            insn.opcode = OP_GO;
        else
            insn.opcode = 4'($urandom_range(OP_BN, OP_BEV));
        // Push the pc toward the ends of the address space now and then
        pick = $urandom_range(0, 9);
        if (pick == 0)
            insn.pc = 64'hFFFF_FFFF_FFFF_FFFF - {56'd0, 8'($urandom)};
        else if (pick == 1)
            insn.pc = {56'd0, 8'($urandom)};
        case ($urandom_range(0, 7))
            0: insn.x_value = 64'd0;
            1: insn.x_value = 64'h8000_0000_0000_0000;
            2: insn.x_value = 64'h7FFF_FFFF_FFFF_FFFF;
            3: insn.x_value = 64'hFFFF_FFFF_FFFF_FFFF;
            4: insn.x_value = 64'd1;
            default: insn.x_value = rand64();
        endcase
        return insn;
    endfunction

    // Present one instruction beat and hold it until accepted.
    task automatic send_insn(input item_t insn);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       = insn;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    // Stall the result side at random
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ready = 1'b0;
            hold_left--;
        end
        else
        begin
            result_ready = 1'b1;
            if (!steady && $urandom_range(0, 3) == 0)
                hold_left = pick_gap();
        end
    end

    // Note accepted beats, check results and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n && item_valid && item_ready)
            sb.note_insn(item);
        if (rst_n && result_valid && result_ready)
            sb.check_resolved(result);
        if (rst_n && ((item_valid && item_ready) || (result_valid && result_ready)))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        item_t       d;
        logic [63:0] branch_x [0:15];
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        steady       = 1'b0;
        idle_cycles  = 0;
        hold_left    = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Pop straight out of reset reads a zero return register, backward ignored
        d = random_insn();
        d.opcode     = OP_POP;
        d.backward   = 1'b1;
        d.rel_offset = 24'hFF_FFFF;
        d.x_field    = 8'hFF;
        send_insn(d);
        // Jump backward below address zero
        d = random_insn();
        d.opcode     = OP_JMP;
        d.backward   = 1'b1;
        d.pc         = 64'd0;
        d.rel_offset = 24'd1;
        send_insn(d);
        // Jump forward past the top, link wraps too
        d = random_insn();
        d.opcode     = OP_JMP;
        d.backward   = 1'b0;
        d.pc         = 64'hFFFF_FFFF_FFFF_FFFC;
        d.rel_offset = 24'hFF_FFFF;
        send_insn(d);
        // Go with immediate Z, sum wraps and low bits clear
        d = random_insn();
        d.opcode      = OP_GO;
        d.z_immediate = 1'b1;
        d.z_field     = 8'hFF;
        d.y_value     = 64'hFFFF_FFFF_FFFF_FFFF;
        send_insn(d);
        // Pushgo with register Z, pc at the very top
        d = random_insn();
        d.opcode      = OP_PUSHGO;
        d.z_immediate = 1'b0;
        d.z_value     = 64'hFFFF_FFFF_FFFF_FFFF;
        d.y_value     = 64'd9;
        d.x_field     = 8'd0;
        d.pc          = 64'hFFFF_FFFF_FFFF_FFFF;
        send_insn(d);
        // Pop after a push, direction bit set
        d = random_insn();
        d.opcode     = OP_POP;
        d.backward   = 1'b1;
        d.rel_offset = 24'd2;
        d.x_field    = 8'h80;
        send_insn(d);
        // Pushj backward with the largest offset and count
        d = random_insn();
        d.opcode     = OP_PUSHJ;
        d.backward   = 1'b1;
        d.pc         = 64'h40;
        d.rel_offset = 24'hFF_FFFF;
        d.x_field    = 8'hFF;
        send_insn(d);
        // Each branch once taken and once not
        branch_x = '{64'h8000_0000_0000_0000, 64'd0,
                     64'd0, 64'd1,
                     64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                     64'hFFFF_FFFF_FFFF_FFFF, 64'd2,
                     64'd0, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'h8000_0000_0000_0000, 64'd0,
                     64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
                     64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF};
        for (int i = 0; i < 16; i++)
        begin
            d = random_insn();
            d.opcode  = OP_BN + 4'(i / 2);
            d.x_value = branch_x[i];
            send_insn(d);
        end
        // Spare opcodes do nothing
        d = random_insn();
        d.opcode = OP_SPARE_FIRST;
        send_insn(d);
        d = random_insn();
        d.opcode = OP_SPARE_LAST;
        send_insn(d);

        // Random part, with a steady stretch every fourth block
        for (int n = 0; n < RANDOM_INSNS; n++)
        begin
            steady = ((n / 200) % 4) == 3;
            send_insn(random_insn());
        end
        steady = 1'b0;
        @(negedge clk);
        item_valid = 1'b0;

        // Drain, then give stray beats a chance to show
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("resolved %0d instructions (25 directed, %0d random), %0d taken",
                 sb.resolved, RANDOM_INSNS, sb.taken_seen);
        $display("stack requests: %0d push, %0d pop; %0d spare opcodes; %0d mismatches",
                 sb.pushes, sb.pops, sb.spare_ops, sb.mismatches);
        if (sb.mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
